### src/lpc_pkg.sv
package lpc_pkg;

    localparam logic [30:0] SAT_LIMIT = 31'h7FFF_FFFF;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_ORDER,
        OP_REDUCE,
        OP_MUL,
        OP_DIVSTEP,
        OP_UPDATE,
        OP_EMIT
    } t_op;

    typedef enum logic [2:0] {
        C_NONE,
        C_NO_INPUT,
        C_ZERO_DIM,
        C_LOOP_DONE,
        C_DIV_BUSY,
        C_NOT_OVER,
        C_OUT_BUSY
    } t_cond;

    typedef logic [2:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic zero_dim;
        logic loop_done;
        logic div_busy;
        logic over_sat;
    } t_stat;

    localparam t_pc STEP_IDLE   = 3'd0;
    localparam t_pc STEP_ORDER  = 3'd1;
    localparam t_pc STEP_REDUCE = 3'd2;
    localparam t_pc STEP_TEST   = 3'd3;
    localparam t_pc STEP_MUL    = 3'd4;
    localparam t_pc STEP_DIV    = 3'd5;
    localparam t_pc STEP_UPDATE = 3'd6;
    localparam t_pc STEP_EMIT   = 3'd7;

    // control store; a step falls through to pc+1 unless its condition holds
    function automatic t_ctrl rom(input t_pc pc);
        t_ctrl w;
        unique case (pc)
            STEP_IDLE:   w = '{OP_CAPTURE, C_NO_INPUT,  STEP_IDLE};
            STEP_ORDER:  w = '{OP_ORDER,   C_ZERO_DIM,  STEP_EMIT};
            STEP_REDUCE: w = '{OP_REDUCE,  C_NONE,      STEP_IDLE};
            STEP_TEST:   w = '{OP_NOP,     C_LOOP_DONE, STEP_EMIT};
            STEP_MUL:    w = '{OP_MUL,     C_NONE,      STEP_IDLE};
            STEP_DIV:    w = '{OP_DIVSTEP, C_DIV_BUSY,  STEP_DIV};
            STEP_UPDATE: w = '{OP_UPDATE,  C_NOT_OVER,  STEP_TEST};
            STEP_EMIT:   w = '{OP_EMIT,    C_OUT_BUSY,  STEP_EMIT};
            default:     w = '{OP_NOP,     C_NONE,      STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

### src/lattice_path_count.sv
// Lattice path counter: one input word carries a grid's row and column counts,
// one output word returns the number of monotone corner-to-corner paths,
// C(rows+cols-2, min(rows,cols)-1), saturated at 2^31-1 with tuser set.
// Dimensions above MAX_DIM are clamped; a zero dimension gives a count of 0.
// Input channel s_axis: ready only while the sequencer sits in its idle step.
// Output channel m_axis: a registered word that holds until taken.
// A small control store steps a shared datapath: setup, then per term
// one multiply and a radix-2 restoring division by the term index.
// The term count is k = min(n-k', k') after reduction, and the bit-serial
// divider works out P = 32 + clog2(MAX_DIM+1) quotient bits (P = 40 at
// MAX_DIM = 128) per term. Saturation ends the loop by the 17th term at the
// latest. One word is worked on at a time.
// A finished word moves to the output register; while the receiver stalls
// with a word already held there, the sequencer waits at its emit step.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register.
module lattice_path_count #(
    parameter int MAX_DIM = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] grid_rows, [15:8] grid_cols
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [30:0] path_count, [31] zero pad
    output logic        m_axis_tuser    // [0] overflow
);

    lpc_pkg::t_pc   r_pc, n_pc;
    lpc_pkg::t_ctrl ctrl;
    lpc_pkg::t_stat stat;
    logic           jump, out_busy, emit;
    logic [30:0]    acc;
    logic           ovf;
    logic           r_out_valid;
    logic [30:0]    r_out_count;
    logic           r_out_ovf;

    assign ctrl     = lpc_pkg::rom(r_pc);
    assign out_busy = r_out_valid && !m_axis_tready;
    assign emit     = (ctrl.op == lpc_pkg::OP_EMIT) && !out_busy;

    lpc_datapath #(
        .MAX_DIM(MAX_DIM)
    ) u_dp (
        .i_clk  (i_clk),
        .i_op   (ctrl.op),
        .i_rows (s_axis_tdata[7:0]),
        .i_cols (s_axis_tdata[15:8]),
        .o_stat (stat),
        .o_acc  (acc),
        .o_ovf  (ovf)
    );

    always_comb begin
        unique case (ctrl.cond)
            lpc_pkg::C_NONE:      jump = 1'b0;
            lpc_pkg::C_NO_INPUT:  jump = !s_axis_tvalid;
            lpc_pkg::C_ZERO_DIM:  jump = stat.zero_dim;
            lpc_pkg::C_LOOP_DONE: jump = stat.loop_done;
            lpc_pkg::C_DIV_BUSY:  jump = stat.div_busy;
            lpc_pkg::C_NOT_OVER:  jump = !stat.over_sat;
            lpc_pkg::C_OUT_BUSY:  jump = out_busy;
            default:              jump = 1'b0;
        endcase
        n_pc = jump ? ctrl.target : r_pc + lpc_pkg::t_pc'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= lpc_pkg::STEP_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_count <= acc;
            r_out_ovf   <= ovf;
        end
    end

    assign s_axis_tready = (r_pc == lpc_pkg::STEP_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_count};
    assign m_axis_tuser  = r_out_ovf;

endmodule

### src/lpc_datapath.sv
module lpc_datapath #(
    parameter int MAX_DIM = 128
) (
    input  logic          i_clk,
    input  lpc_pkg::t_op  i_op,
    input  logic [7:0]    i_rows,
    input  logic [7:0]    i_cols,
    output lpc_pkg::t_stat o_stat,
    output logic [30:0]   o_acc,
    output logic          o_ovf
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EXT_W = (DIM_W > 8) ? DIM_W : 8;
    localparam int N_W   = DIM_W + 1;
    localparam int P_W   = 31 + N_W;
    localparam int CNT_W = $clog2(P_W);

    logic [DIM_W-1:0] r_rows, r_cols, r_k, r_i, r_rem;
    logic [N_W-1:0]   r_n;
    logic [30:0]      r_acc;
    logic             r_ovf;
    logic [P_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;

    logic [DIM_W-1:0] min_side;
    logic [N_W-1:0]   diff, factor;
    logic [DIM_W:0]   rem_sh;
    logic             ge, over;

    function automatic logic [DIM_W-1:0] clamp(input logic [7:0] d);
        logic [EXT_W-1:0] e;
        e = EXT_W'(d);
        if (e > EXT_W'(MAX_DIM)) begin
            e = EXT_W'(MAX_DIM);
        end
        return DIM_W'(e);
    endfunction

    assign min_side = (r_rows < r_cols) ? r_rows : r_cols;
    assign diff   = r_n - N_W'(r_k);
    assign factor = diff + N_W'(r_i);
    assign rem_sh = {r_rem, r_quo[P_W-1]};
    assign ge     = rem_sh >= (DIM_W + 1)'(r_i);
    assign over   = r_quo > P_W'(lpc_pkg::SAT_LIMIT);

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            lpc_pkg::OP_CAPTURE: begin
                r_rows <= clamp(i_rows);
                r_cols <= clamp(i_cols);
            end
            lpc_pkg::OP_ORDER: begin
                r_n   <= N_W'(r_rows) + N_W'(r_cols) - N_W'(2);
                r_k   <= min_side - DIM_W'(1);
                r_acc <= '0;
                r_ovf <= 1'b0;
            end
            lpc_pkg::OP_REDUCE: begin
                if (diff < N_W'(r_k)) begin
                    r_k <= DIM_W'(diff);
                end
                r_acc <= 31'd1;
                r_i   <= DIM_W'(1);
            end
            lpc_pkg::OP_MUL: begin
                // acc times the term n-k+i; quotient shifts in where dividend shifts out
                r_quo <= P_W'(r_acc) * P_W'(factor);
                r_rem <= '0;
                r_cnt <= CNT_W'(P_W - 1);
            end
            lpc_pkg::OP_DIVSTEP: begin
                r_rem <= ge ? DIM_W'(rem_sh - (DIM_W + 1)'(r_i)) : DIM_W'(rem_sh);
                r_quo <= {r_quo[P_W-2:0], ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            lpc_pkg::OP_UPDATE: begin
                if (over) begin
                    r_acc <= lpc_pkg::SAT_LIMIT;
                    r_ovf <= 1'b1;
                end else begin
                    r_acc <= r_quo[30:0];
                end
                r_i <= r_i + DIM_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_stat.zero_dim  = (r_rows == '0) || (r_cols == '0);
    assign o_stat.loop_done = r_i > r_k;
    assign o_stat.div_busy  = r_cnt != '0;
    assign o_stat.over_sat  = over;
    assign o_acc = r_acc;
    assign o_ovf = r_ovf;

endmodule

### sim/lpc_path_checker.sv
module lpc_path_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [15:0] i_in_data,    // [7:0] grid_rows, [15:8] grid_cols
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,   // [30:0] path_count, [31] zero pad
    input  logic        i_out_user,   // [0] overflow
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 128;

    typedef struct packed {
        logic [30:0] count;
        logic        ovf;
    } t_paths;

    t_paths paths_due[$];

    // C(rows+cols-2, min-1) by the multiplicative rule, saturating
    function automatic t_paths count_paths(input logic [7:0] rows_in,
                                           input logic [7:0] cols_in);
        logic [63:0] rows, cols, short_side, n, k, acc, i;
        t_paths      res;
        rows  = (rows_in > MAX_DIM) ? 64'(MAX_DIM) : 64'(rows_in);
        cols  = (cols_in > MAX_DIM) ? 64'(MAX_DIM) : 64'(cols_in);
        res.count = '0;
        res.ovf   = 1'b0;
        if (rows == 0 || cols == 0) begin
            return res;
        end
        short_side = (rows < cols) ? rows : cols;
        n = rows + cols - 2;
        k = short_side - 1;
        if (n - k < k) begin
            k = n - k;
        end
        acc = 1;
        for (i = 1; i <= k; i++) begin
            acc = acc * (n - k + i) / i;
            // partial coefficients never shrink, so stop at the first overshoot
            if (acc > 64'(lpc_pkg::SAT_LIMIT)) begin
                acc     = 64'(lpc_pkg::SAT_LIMIT);
                res.ovf = 1'b1;
                break;
            end
        end
        res.count = acc[30:0];
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_paths got;
        t_paths want;
        if (i_rst_n) begin
            // result side first: a word taken this edge never belongs to the
            // request taken at the same edge
            if (i_out_valid && i_out_ready) begin
                got = '{i_out_data[30:0], i_out_user};
                if (paths_due.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("[%0t] unexpected word: count=%0d ovf=%0b",
                                 $realtime, got.count, got.ovf);
                    end
                end else begin
                    want = paths_due.pop_front();
                    if (got.count !== want.count || got.ovf !== want.ovf) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display({"[%0t] mismatch: count exp=%0d got=%0d,",
                                      " ovf exp=%0b got=%0b"},
                                     $realtime, want.count, got.count,
                                     want.ovf, got.ovf);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                paths_due.push_back(count_paths(i_in_data[7:0], i_in_data[15:8]));
            end
            o_pending = paths_due.size();
        end
    end

endmodule

### sim/tb_lattice_path_count.sv
module tb_lattice_path_count;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [7:0] grid_rows, [15:8] grid_cols
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [30:0] path_count, [31] zero pad
    logic        m_axis_tuser;    // [0] overflow

    int fail_count;
    int words_due;
    bit quiet;                    // no idling on either side while set

    lattice_path_count #(
        .MAX_DIM(128)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    lpc_path_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_fail_count(fail_count),
        .o_pending   (words_due)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #6 i_clk = ~i_clk;

    initial begin
        #15_000_000;
        $display("status: fail");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 12);
    end

    task automatic send_grid(input logic [7:0] rows, input logic [7:0] cols);
        while (!quiet && $urandom_range(99) < 12) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {cols, rows};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [7:0] rows;
        logic [7:0] cols;
        int         sel;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        quiet         = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners, clamping, zero dims, saturation edge
        send_grid(8'd1,   8'd1);
        send_grid(8'd1,   8'd128);
        send_grid(8'd128, 8'd1);
        send_grid(8'd2,   8'd2);
        send_grid(8'd3,   8'd3);
        send_grid(8'd2,   8'd128);
        send_grid(8'd3,   8'd128);
        send_grid(8'd128, 8'd128);
        send_grid(8'd255, 8'd255);
        send_grid(8'd129, 8'd1);
        send_grid(8'd200, 8'd3);
        send_grid(8'd3,   8'd200);
        send_grid(8'd0,   8'd5);
        send_grid(8'd5,   8'd0);
        send_grid(8'd0,   8'd0);
        send_grid(8'd255, 8'd0);
        send_grid(8'd17,  8'd17);
        send_grid(8'd18,  8'd18);
        send_grid(8'd17,  8'd18);
        send_grid(8'd8,   8'd33);
        send_grid(8'd170, 8'd85);
        send_grid(8'd85,  8'd170);

        for (int n = 0; n < 78; n++) begin
            quiet = (n >= 30 && n < 60);
            sel = $urandom_range(99);
            if (sel < 50) begin
                rows = 8'($urandom_range(20, 1));
                cols = 8'($urandom_range(20, 1));
            end else if (sel < 65) begin
                rows = 8'($urandom_range(3, 1));
                cols = 8'($urandom_range(255, 1));
                if ($urandom_range(1)) begin
                    {rows, cols} = {cols, rows};
                end
            end else if (sel < 85) begin
                rows = 8'($urandom);
                cols = 8'($urandom);
            end else if (sel < 92) begin
                rows = 8'($urandom);
                cols = 8'd0;
                if ($urandom_range(1)) begin
                    {rows, cols} = {cols, rows};
                end
            end else begin
                // around where the count crosses the limit
                rows = 8'($urandom_range(20, 14));
                cols = 8'($urandom_range(20, 14));
            end
            send_grid(rows, cols);
        end
        quiet         = 1'b0;
        s_axis_tvalid = 1'b0;

        while (words_due != 0) begin
            @(posedge i_clk);
        end
        repeat (3000) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

### files.f
src/lpc_pkg.sv
src/lpc_datapath.sv
src/lattice_path_count.sv
sim/lpc_path_checker.sv
sim/tb_lattice_path_count.sv
